>>> rtl/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

   localparam int CODE_BITS = 5;
   localparam int PART_BITS = 7;
   localparam int PLEN_BITS = 3;
   localparam int WORD_BITS = 8;
   localparam int CHAR_BITS = 8;

   localparam logic [CHAR_BITS-1:0] NEWLINE_CHAR = 8'd10;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   // Codes of the non-letter characters in the five-bit alphabet.
   localparam logic [CODE_BITS-1:0] CODE_SPACE = 5'd26;
   localparam logic [CODE_BITS-1:0] CODE_DOT   = 5'd27;
   localparam logic [CODE_BITS-1:0] CODE_COMMA = 5'd28;
   localparam logic [CODE_BITS-1:0] CODE_DASH  = 5'd29;
   localparam logic [CODE_BITS-1:0] CODE_APOS  = 5'd30;
   localparam logic [CODE_BITS-1:0] CODE_QUEST = 5'd31;

   typedef struct packed {
      logic                 hit;
      logic [CODE_BITS-1:0] code;
   } ptc_code_type;

   typedef struct packed {
      logic                 hit;
      logic [CHAR_BITS-1:0] ch;
   } ptc_match_type;

   // Everything one item produces, plus the partial code it leaves behind.
   typedef struct packed {
      logic [1:0]           count;
      logic [CHAR_BITS-1:0] ch0;
      logic [CHAR_BITS-1:0] ch1;
      logic [PART_BITS-1:0] bits;
      logic [PLEN_BITS-1:0] len;
   } ptc_result_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 last;
   } ptc_slot_type;

   function automatic ptc_code_type encode_char(input logic [CHAR_BITS-1:0] c);
      ptc_code_type         r;
      logic [CHAR_BITS-1:0] diff;
      r    = '0;
      diff = c - 8'h41;
      case (c) inside
         [8'h41:8'h5A]: begin
            r.hit  = 1'b1;
            r.code = diff[CODE_BITS-1:0];
         end
         8'h20: r = '{1'b1, CODE_SPACE};
         8'h2E: r = '{1'b1, CODE_DOT};
         8'h2C: r = '{1'b1, CODE_COMMA};
         8'h2D: r = '{1'b1, CODE_DASH};
         8'h27: r = '{1'b1, CODE_APOS};
         8'h3F: r = '{1'b1, CODE_QUEST};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Prefix code lookup: a word of the given length, right aligned in bits.
   function automatic ptc_match_type match_word(input logic [3:0] len,
                                                input logic [WORD_BITS-1:0] bits);
      ptc_match_type r;
      r = '0;
      case (len)
         4'd3: begin
            case (bits)
               8'h05: r = '{1'b1, 8'h20};
               8'h06: r = '{1'b1, 8'h45};
               8'h07: r = '{1'b1, 8'h50};
               default: r = '0;
            endcase
         end
         4'd4: begin
            case (bits)
               8'h05: r = '{1'b1, 8'h43};
               8'h01: r = '{1'b1, 8'h44};
               8'h07: r = '{1'b1, 8'h49};
               8'h06: r = '{1'b1, 8'h4B};
               8'h08: r = '{1'b1, 8'h52};
               default: r = '0;
            endcase
         end
         4'd5: begin
            case (bits)
               8'h09: r = '{1'b1, 8'h46};
               8'h04: r = '{1'b1, 8'h4C};
               8'h05: r = '{1'b1, 8'h4F};
               8'h06: r = '{1'b1, 8'h53};
               8'h07: r = '{1'b1, 8'h54};
               default: r = '0;
            endcase
         end
         4'd6: begin
            case (bits)
               8'h00: r = '{1'b1, 8'h27};
               8'h03: r = '{1'b1, 8'h2C};
               8'h11: r = '{1'b1, 8'h2E};
               8'h01: r = '{1'b1, 8'h3F};
               8'h25: r = '{1'b1, 8'h41};
               8'h10: r = '{1'b1, 8'h48};
               8'h02: r = '{1'b1, 8'h57};
               default: r = '0;
            endcase
         end
         4'd8: begin
            case (bits)
               8'h91: r = '{1'b1, 8'h2D};
               8'h9A: r = '{1'b1, 8'h42};
               8'h9B: r = '{1'b1, 8'h47};
               8'h98: r = '{1'b1, 8'h4A};
               8'h99: r = '{1'b1, 8'h4D};
               8'h9E: r = '{1'b1, 8'h4E};
               8'h9F: r = '{1'b1, 8'h51};
               8'h9C: r = '{1'b1, 8'h55};
               8'h9D: r = '{1'b1, 8'h56};
               8'h92: r = '{1'b1, 8'h58};
               8'h93: r = '{1'b1, 8'h59};
               8'h90: r = '{1'b1, 8'h5A};
               default: r = '0;
            endcase
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/ptc_decode.sv
`timescale 1ns / 1ps

module ptc_decode (
   input  logic                          opcode,
   input  logic [ptc_pkg::CHAR_BITS-1:0] char_code,
   input  logic [ptc_pkg::PART_BITS-1:0] part_bits,
   input  logic [ptc_pkg::PLEN_BITS-1:0] part_len,
   output ptc_pkg::ptc_result_type       result
);
   import ptc_pkg::*;

   ptc_code_type   enc;
   ptc_match_type  m;
   logic [PART_BITS-1:0] bits_q;
   logic [PLEN_BITS-1:0] len_q;
   logic [3:0]           len_w;
   logic [WORD_BITS-1:0] word;

   assign enc = encode_char(char_code);

   // A character's five bits shift in, MSB first, with a lookup after each.
   always_comb begin
      result       = '0;
      result.bits  = part_bits;
      result.len   = part_len;
      bits_q       = part_bits;
      len_q        = part_len;
      len_w        = '0;
      word         = '0;
      m            = '0;
      if (opcode == OP_EOL) begin
         result.count = 2'd1;
         result.ch0   = NEWLINE_CHAR;
         result.bits  = '0;
         result.len   = '0;
      end else if (enc.hit) begin
         for (int b = CODE_BITS - 1; b >= 0; b--) begin
            len_w = {1'b0, len_q} + 4'd1;
            word  = {bits_q, enc.code[b]};
            m     = match_word(len_w, word);
            if (m.hit) begin
               if (result.count == 2'd0) begin
                  result.ch0 = m.ch;
               end else begin
                  result.ch1 = m.ch;
               end
               if (result.count != 2'd2) begin
                  result.count = result.count + 2'd1;
               end
               bits_q = '0;
               len_q  = '0;
            end else if (len_w >= 4'd8) begin
               bits_q = '0;
               len_q  = '0;
            end else begin
               bits_q = word[PART_BITS-1:0];
               len_q  = len_w[PLEN_BITS-1:0];
            end
         end
         result.bits = bits_q;
         result.len  = len_q;
      end
   end

endmodule

>>> rtl/five_bit_to_prefix_code_transcoder_core.sv
`timescale 1ns / 1ps
// A result passes through the input register and then the result buffer on its way to the rsp_ ports.
// Throughput: one item per cycle while rsp_stall is low and each gives at most one result;
// an item that gives two results sends them through the single result port one after another.
// A two-entry result buffer absorbs results while rsp_stall is high; req_stall rises once
// the item in the input register finds no room left for its results.
// Reset (synchronous, active high) clears the partial code and empties the input register and the buffer.
module five_bit_to_prefix_code_transcoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [ptc_pkg::CHAR_BITS-1:0] req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ptc_pkg::CHAR_BITS-1:0] rsp_out_char,
   output logic                          rsp_last_of_run
);
   import ptc_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff, in_op_in;
   logic [CHAR_BITS-1:0] in_char_ff, in_char_in;
   logic [PART_BITS-1:0] part_bits_ff, part_bits_in;
   logic [PLEN_BITS-1:0] part_len_ff, part_len_in;
   ptc_slot_type         slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;

   ptc_result_type res;
   ptc_slot_type   r0, r1, rem0;
   logic           accept, pop, process;
   logic [1:0]     rem_cnt, free_cnt, push_cnt;

   ptc_decode u_decode (
      .opcode    (in_op_ff),
      .char_code (in_char_ff),
      .part_bits (part_bits_ff),
      .part_len  (part_len_ff),
      .result    (res)
   );

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_out_char    = slot0_ff.ch;
   assign rsp_last_of_run = slot0_ff.last;
   assign pop             = rsp_valid && !rsp_stall;

   assign rem_cnt  = count_ff - {1'b0, pop};
   assign free_cnt = 2'd2 - rem_cnt;
   assign process  = in_valid_ff && (res.count <= free_cnt);
   assign push_cnt = process ? res.count : 2'd0;

   assign req_stall = in_valid_ff && !process;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      in_op_in     = accept ? req_opcode : in_op_ff;
      in_char_in   = accept ? req_char_code : in_char_ff;
      part_bits_in = process ? res.bits : part_bits_ff;
      part_len_in  = process ? res.len : part_len_ff;

      r0.ch   = res.ch0;
      r0.last = (res.count == 2'd1);
      r1.ch   = res.ch1;
      r1.last = 1'b1;

      // Entries left after this cycle's pop, then the new results behind them.
      rem0     = pop ? slot1_ff : slot0_ff;
      count_in = rem_cnt + push_cnt;
      case (rem_cnt)
         2'd0: begin
            slot0_in = r0;
            slot1_in = r1;
         end
         2'd1: begin
            slot0_in = rem0;
            slot1_in = r0;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         part_bits_ff <= '0;
         part_len_ff  <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         part_bits_ff <= part_bits_in;
         part_len_ff  <= part_len_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff   <= in_op_in;
      in_char_ff <= in_char_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   // The input side only holds off while an item waits for buffer room.
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with no item waiting");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overfilled");

   // Partial bits never reach above the recorded length.
   a_part_fits: assert property (@(posedge clock) disable iff (reset)
      (part_bits_ff >> part_len_ff) == '0)
      else $error("partial code wider than its length");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (process && in_op_ff == OP_EOL) |=> (part_len_ff == '0 && part_bits_ff == '0))
      else $error("end of line left partial bits");

   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> slot1_ff.last)
      else $error("buffer tail is not the end of a run");

endmodule
